// ===== hw/rtl/fresrefl_pkg.sv =====
// ----------------------------------------------------------------------------
// fresrefl_pkg
// Shared widths and fixed-point constants of the Fresnel reflectance pipeline.
// ----------------------------------------------------------------------------
package fresrefl_pkg;

  localparam int VEC_FRAC_BITS_DEF = 14;

  // A value in [0, 1.0] held in Q30 needs 31 bits, its square in Q60 needs 61.
  localparam int Q30_W   = 31;
  localparam int Q60_W   = 61;
  localparam int FRAC_Q  = 30;
  localparam int IDX_W   = 16;
  localparam int IDX_FRAC = 12;
  localparam int PROD_W  = IDX_W + Q30_W;
  localparam int RAT_W   = PROD_W + 1;

  localparam logic [Q60_W-1:0] ONE_Q60 = Q60_W'(1) << 60;
  localparam logic [Q30_W-1:0] ONE_Q30 = Q30_W'(1) << FRAC_Q;
  localparam logic [15:0]      KR_ONE  = 16'h8000;
  localparam int               KR_SHIFT = 46;

endpackage

// ===== hw/rtl/fresrefl_front.sv =====
// ----------------------------------------------------------------------------
// fresrefl_front
// Dot product of incident and normal, clamp to Q30 cosine, and 1 - cos^2.
// ----------------------------------------------------------------------------
module fresrefl_front #(
  parameter int VEC_FRAC_BITS = fresrefl_pkg::VEC_FRAC_BITS_DEF
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              en,
  input  logic                              in_valid,
  input  logic signed [15:0]                incident_x,
  input  logic signed [15:0]                incident_y,
  input  logic signed [15:0]                incident_z,
  input  logic signed [15:0]                normal_x,
  input  logic signed [15:0]                normal_y,
  input  logic signed [15:0]                normal_z,
  input  logic [fresrefl_pkg::IDX_W-1:0]    refr_index,
  output logic                              out_valid,
  output logic [fresrefl_pkg::Q30_W-1:0]    cos_q30,
  output logic [fresrefl_pkg::IDX_W-1:0]    idx,
  output logic                              leaving,
  output logic [fresrefl_pkg::Q60_W-1:0]    sin_sq
);

  localparam int FB2 = 2 * VEC_FRAC_BITS;
  localparam int CW  = (FB2 + 1 > 32) ? FB2 + 1 : 32;
  localparam logic [CW-1:0] ONE_RAW = CW'(1) << FB2;

  logic                v1, v2, v3, v4;
  logic signed [31:0]  px, py, pz;
  logic [15:0]         idx1, idx2, idx3;
  logic [30:0]         c2, c3;
  logic                lv2, lv3;
  logic [61:0]         cc3;

  logic signed [32:0]  dot;
  logic [32:0]         magd;
  logic [CW-1:0]       magw, magc, cfull;

  assign dot  = 33'(px) + 33'(py) + 33'(pz);
  assign magd = dot[32] ? 33'(-dot) : 33'(dot);
  assign magw = CW'(magd[31:0]);
  assign magc = (magw > ONE_RAW) ? ONE_RAW : magw;

  generate
    if (FB2 >= 30) begin : g_shr
      assign cfull = magc >> (FB2 - 30);
    end else begin : g_shl
      assign cfull = magc << (30 - FB2);
    end
  endgenerate

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
      v4 <= 1'b0;
    end else if (en) begin
      v1 <= in_valid;
      v2 <= v1;
      v3 <= v2;
      v4 <= v3;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      px   <= incident_x * normal_x;
      py   <= incident_y * normal_y;
      pz   <= incident_z * normal_z;
      // A zero index is taken as the smallest one.
      idx1 <= (refr_index == '0) ? 16'd1 : refr_index;

      c2   <= cfull[30:0];
      lv2  <= !dot[32] && (dot != '0);
      idx2 <= idx1;

      cc3  <= c2 * c2;
      c3   <= c2;
      lv3  <= lv2;
      idx3 <= idx2;

      sin_sq  <= fresrefl_pkg::ONE_Q60 - cc3[60:0];
      cos_q30 <= c3;
      leaving <= lv3;
      idx     <= idx3;
    end
  end

  assign out_valid = v4;

endmodule

// ===== hw/rtl/fresrefl_sqrt.sv =====
// ----------------------------------------------------------------------------
// fresrefl_sqrt
// Pipelined floor square root of a Q60 value, one root bit per stage.
// ----------------------------------------------------------------------------
module fresrefl_sqrt #(
  parameter int SW = 1
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            en,
  input  logic                            in_valid,
  input  logic [fresrefl_pkg::Q60_W-1:0]  in_x,
  input  logic [SW-1:0]                   in_side,
  output logic                            out_valid,
  output logic [fresrefl_pkg::Q30_W-1:0]  out_root,
  output logic [SW-1:0]                   out_side
);

  localparam int NB = fresrefl_pkg::Q30_W;
  localparam int RW = 2 * NB + 1;

  logic [RW-1:0] rem  [0:NB];
  logic [NB-1:0] root [0:NB];
  logic [SW-1:0] side [0:NB];
  logic          vld  [0:NB];

  assign rem[0]  = RW'(in_x);
  assign root[0] = '0;
  assign side[0] = in_side;
  assign vld[0]  = in_valid;

  for (genvar k = 0; k < NB; k++) begin : g_stage
    localparam int I = NB - 1 - k;
    logic [RW-1:0] trial;
    logic          take;

    // Only bits above I are set in the partial root, so OR is the sum here.
    assign trial = (RW'(root[k]) << (I + 1)) | (RW'(1) << (2 * I));
    assign take  = rem[k] >= trial;

    always_ff @(posedge clk) begin
      if (rst) begin
        vld[k+1] <= 1'b0;
      end else if (en) begin
        vld[k+1] <= vld[k];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        rem[k+1]  <= take ? rem[k] - trial : rem[k];
        root[k+1] <= take ? (root[k] | (NB'(1) << I)) : root[k];
        side[k+1] <= side[k];
      end
    end
  end

  assign out_valid = vld[NB];
  assign out_root  = root[NB];
  assign out_side  = side[NB];

endmodule

// ===== hw/rtl/fresrefl_div.sv =====
// ----------------------------------------------------------------------------
// fresrefl_div
// Pipelined restoring divider: floor(({hi, lo}) / den), one quotient bit per
// stage, for hi below den.
// ----------------------------------------------------------------------------
module fresrefl_div #(
  parameter int HW = 16,
  parameter int QB = 30,
  parameter int SW = 1
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          en,
  input  logic          in_valid,
  input  logic [HW-1:0] in_hi,
  input  logic [QB-1:0] in_lo,
  input  logic [HW-1:0] in_den,
  input  logic [SW-1:0] in_side,
  output logic          out_valid,
  output logic [QB-1:0] out_q,
  output logic [SW-1:0] out_side
);

  logic [HW-1:0] rem  [0:QB];
  logic [QB-1:0] lo   [0:QB];
  logic [QB-1:0] q    [0:QB];
  logic [HW-1:0] den  [0:QB];
  logic [SW-1:0] side [0:QB];
  logic          vld  [0:QB];

  assign rem[0]  = in_hi;
  assign lo[0]   = in_lo;
  assign q[0]    = '0;
  assign den[0]  = in_den;
  assign side[0] = in_side;
  assign vld[0]  = in_valid;

  for (genvar k = 0; k < QB; k++) begin : g_stage
    logic [HW:0] rem2, diff;
    logic        take;

    assign rem2 = {rem[k], lo[k][QB-1]};
    assign diff = rem2 - {1'b0, den[k]};
    assign take = rem2 >= {1'b0, den[k]};

    always_ff @(posedge clk) begin
      if (rst) begin
        vld[k+1] <= 1'b0;
      end else if (en) begin
        vld[k+1] <= vld[k];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        rem[k+1]  <= take ? diff[HW-1:0] : rem2[HW-1:0];
        lo[k+1]   <= lo[k] << 1;
        q[k+1]    <= (q[k] << 1) | QB'(take);
        den[k+1]  <= den[k];
        side[k+1] <= side[k];
      end
    end
  end

  assign out_valid = vld[QB];
  assign out_q     = q[QB];
  assign out_side  = side[QB];

endmodule

// ===== hw/rtl/fresnel_reflectance.sv =====
// ----------------------------------------------------------------------------
// fresnel_reflectance
// Unpolarized Fresnel reflectance from incident direction, normal and index.
//
//  channel | direction | tdata / tuser
//  s_*     | in        | tdata: incident_x,y,z, normal_x,y,z, refr_index
//  m_*     | out       | tdata: reflectance; tuser: total_internal
//
// One item enters per cycle unless a result waits at the output register.
// The pipeline holds two 31-stage square roots and three 30-stage dividers.
// Reset clears only the valid bits. The whole pipeline holds while a result
// waits at the output register, so a stall loses and repeats nothing.
// ----------------------------------------------------------------------------
module fresnel_reflectance #(
  parameter int VEC_FRAC_BITS = fresrefl_pkg::VEC_FRAC_BITS_DEF
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         s_tvalid,
  output logic         s_tready,
  // incident_x, incident_y, incident_z, normal_x, normal_y, normal_z, refr_index
  input  logic [111:0] s_tdata,
  output logic         m_tvalid,
  input  logic         m_tready,
  // reflectance
  output logic [15:0]  m_tdata,
  // total_internal
  output logic         m_tuser
);

  logic en;
  assign en       = !m_tvalid || m_tready;
  assign s_tready = en;

  // Cosine and 1 - cos^2.
  logic        f_vld, f_leave;
  logic [30:0] f_c;
  logic [15:0] f_idx;
  logic [60:0] f_v;

  fresrefl_front #(.VEC_FRAC_BITS(VEC_FRAC_BITS)) u_front (
    .clk        (clk),
    .rst        (rst),
    .en         (en),
    .in_valid   (s_tvalid && s_tready),
    .incident_x (s_tdata[15:0]),
    .incident_y (s_tdata[31:16]),
    .incident_z (s_tdata[47:32]),
    .normal_x   (s_tdata[63:48]),
    .normal_y   (s_tdata[79:64]),
    .normal_z   (s_tdata[95:80]),
    .refr_index (s_tdata[111:96]),
    .out_valid  (f_vld),
    .cos_q30    (f_c),
    .idx        (f_idx),
    .leaving    (f_leave),
    .sin_sq     (f_v)
  );

  // Incident sine.
  logic        s1_vld;
  logic [30:0] s1_root;
  logic [47:0] s1_side;

  fresrefl_sqrt #(.SW(48)) u_sqrt_i (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .in_valid  (f_vld),
    .in_x      (f_v),
    .in_side   ({f_leave, f_idx, f_c}),
    .out_valid (s1_vld),
    .out_root  (s1_root),
    .out_side  (s1_side)
  );

  // Leaving the material the transmitted sine is a product, entering a quotient.
  logic        sm_vld, sm_leave;
  logic [30:0] sm_sini, sm_c;
  logic [15:0] sm_idx;
  logic [46:0] sm_prod;

  always_ff @(posedge clk) begin
    if (rst) begin
      sm_vld <= 1'b0;
    end else if (en) begin
      sm_vld <= s1_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      sm_sini  <= s1_root;
      sm_prod  <= s1_root * s1_side[46:31];
      sm_c     <= s1_side[30:0];
      sm_idx   <= s1_side[46:31];
      sm_leave <= s1_side[47];
    end
  end

  logic        d1_tir_in;
  logic [15:0] d1_hi;
  logic        d1_vld;
  logic [29:0] d1_q;
  logic [78:0] d1_side;

  assign d1_hi     = 16'(sm_sini[30:18]);
  assign d1_tir_in = sm_leave ? (|sm_prod[46:42]) : (d1_hi >= sm_idx);

  fresrefl_div #(.HW(16), .QB(30), .SW(79)) u_div_t (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .in_valid  (sm_vld),
    .in_hi     (d1_hi),
    .in_lo     ({sm_sini[17:0], 12'b0}),
    .in_den    (sm_idx),
    .in_side   ({sm_leave, d1_tir_in, sm_prod[41:12], sm_idx, sm_c}),
    .out_valid (d1_vld),
    .out_q     (d1_q),
    .out_side  (d1_side)
  );

  // Transmitted sine, its square, and 1 - sin_t^2.
  logic        x_vld, y_vld, z_vld;
  logic [29:0] x_sint;
  logic        x_tir, y_tir, z_tir;
  logic [30:0] x_c, y_c, z_c;
  logic [15:0] x_idx, y_idx, z_idx;
  logic [59:0] y_sq;
  logic [60:0] z_v;

  always_ff @(posedge clk) begin
    if (rst) begin
      x_vld <= 1'b0;
      y_vld <= 1'b0;
      z_vld <= 1'b0;
    end else if (en) begin
      x_vld <= d1_vld;
      y_vld <= x_vld;
      z_vld <= y_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      x_sint <= d1_side[78] ? d1_side[76:47] : d1_q;
      x_tir  <= d1_side[77];
      x_idx  <= d1_side[46:31];
      x_c    <= d1_side[30:0];

      y_sq   <= x_sint * x_sint;
      y_tir  <= x_tir;
      y_idx  <= x_idx;
      y_c    <= x_c;

      z_v    <= fresrefl_pkg::ONE_Q60 - 61'(y_sq);
      z_tir  <= y_tir;
      z_idx  <= y_idx;
      z_c    <= y_c;
    end
  end

  // Transmitted cosine.
  logic        s2_vld;
  logic [30:0] s2_root;
  logic [47:0] s2_side;

  fresrefl_sqrt #(.SW(48)) u_sqrt_t (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .in_valid  (z_vld),
    .in_x      (z_v),
    .in_side   ({z_tir, z_idx, z_c}),
    .out_valid (s2_vld),
    .out_root  (s2_root),
    .out_side  (s2_side)
  );

  // The s and p terms are |a-b|/(a+b) of (n*c, cos_t) and (c, n*cos_t); their
  // squares are summed, so which one is which does not matter.
  logic        p_vld, p_tir;
  logic [46:0] p_a1, p_b1, p_a2, p_b2;

  always_ff @(posedge clk) begin
    if (rst) begin
      p_vld <= 1'b0;
    end else if (en) begin
      p_vld <= s2_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      p_a1  <= s2_side[46:31] * s2_side[30:0];
      p_b1  <= 47'(s2_root) << fresrefl_pkg::IDX_FRAC;
      p_a2  <= 47'(s2_side[30:0]) << fresrefl_pkg::IDX_FRAC;
      p_b2  <= s2_side[46:31] * s2_root;
      p_tir <= s2_side[47];
    end
  end

  logic [46:0] num1_c, num2_c;
  logic [47:0] den1_c, den2_c;

  assign num1_c = (p_a1 >= p_b1) ? p_a1 - p_b1 : p_b1 - p_a1;
  assign num2_c = (p_a2 >= p_b2) ? p_a2 - p_b2 : p_b2 - p_a2;
  assign den1_c = 48'(p_a1) + 48'(p_b1);
  assign den2_c = 48'(p_a2) + 48'(p_b2);

  logic        q_vld, q_tir, q_one1, q_one2;
  logic [47:0] q_num1, q_num2, q_den1, q_den2;

  always_ff @(posedge clk) begin
    if (rst) begin
      q_vld <= 1'b0;
    end else if (en) begin
      q_vld <= p_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      // A term whose quotient would reach 1.0 is forced to 1.0.
      q_one1 <= (den1_c == '0) || (48'(num1_c) >= den1_c);
      q_one2 <= (den2_c == '0) || (48'(num2_c) >= den2_c);
      q_num1 <= 48'(num1_c);
      q_num2 <= 48'(num2_c);
      q_den1 <= den1_c;
      q_den2 <= den2_c;
      q_tir  <= p_tir;
    end
  end

  logic        da_vld, db_vld;
  logic [29:0] da_q, db_q;
  logic [1:0]  da_side;
  logic        db_side;

  fresrefl_div #(.HW(48), .QB(30), .SW(2)) u_div_a (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .in_valid  (q_vld),
    .in_hi     (q_one1 ? '0 : q_num1),
    .in_lo     ('0),
    .in_den    (q_den1),
    .in_side   ({q_tir, q_one1}),
    .out_valid (da_vld),
    .out_q     (da_q),
    .out_side  (da_side)
  );

  fresrefl_div #(.HW(48), .QB(30), .SW(1)) u_div_b (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .in_valid  (q_vld),
    .in_hi     (q_one2 ? '0 : q_num2),
    .in_lo     ('0),
    .in_den    (q_den2),
    .in_side   (q_one2),
    .out_valid (db_vld),
    .out_q     (db_q),
    .out_side  (db_side)
  );

  logic [30:0] r1_c, r2_c;
  assign r1_c = da_side[0] ? fresrefl_pkg::ONE_Q30 : {1'b0, da_q};
  assign r2_c = db_side    ? fresrefl_pkg::ONE_Q30 : {1'b0, db_q};

  logic        r_vld, r_tir;
  logic [61:0] r_sq1, r_sq2;

  always_ff @(posedge clk) begin
    if (rst) begin
      r_vld <= 1'b0;
    end else if (en) begin
      r_vld <= da_vld && db_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      r_sq1 <= r1_c * r1_c;
      r_sq2 <= r2_c * r2_c;
      r_tir <= da_side[1];
    end
  end

  logic [62:0] sum_c;
  logic [16:0] kr_c;

  assign sum_c = 63'(r_sq1) + 63'(r_sq2);
  assign kr_c  = sum_c[fresrefl_pkg::KR_SHIFT+16:fresrefl_pkg::KR_SHIFT];

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (en) begin
      m_tvalid <= r_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      if (r_tir || (kr_c > 17'(fresrefl_pkg::KR_ONE))) begin
        m_tdata <= fresrefl_pkg::KR_ONE;
      end else begin
        m_tdata <= kr_c[15:0];
      end
      m_tuser <= r_tir;
    end
  end

endmodule

// ===== hw/rtl/fresrefl_chk.sv =====
// ----------------------------------------------------------------------------
// fresrefl_chk
// Port-level checks of the Fresnel reflectance block.
// ----------------------------------------------------------------------------
module fresrefl_chk (
  input logic        clk,
  input logic        rst,
  input logic        s_tvalid,
  input logic        s_tready,
  input logic        m_tvalid,
  input logic        m_tready,
  input logic [15:0] m_tdata,
  input logic        m_tuser
);

  // A result that is not taken stays as it is.
  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
    else $error("result changed while stalled");

  // Total internal reflection always reports full reflectance.
  a_tir_one: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tuser |-> m_tdata == fresrefl_pkg::KR_ONE)
    else $error("total internal reflection without reflectance 1.0");

  a_range: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> m_tdata <= fresrefl_pkg::KR_ONE)
    else $error("reflectance above 1.0");

  // With the output register empty nothing may hold an offered item back.
  a_ready: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && !m_tvalid |-> s_tready)
    else $error("input stalled with empty output");

endmodule

bind fresnel_reflectance fresrefl_chk u_chk (.*);
